>>> rtl/vnd_pkg.sv
// Shared types, constants and extent clamping helpers for the volume
// nearest-neighbor downsampler. No dependencies.
`default_nettype none

package vnd_pkg;

    // Geometry and payload widths
    localparam int AXES        = 3;
    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = 13;   // holds 1..MAX_DIM
    localparam int POS_W       = 12;   // holds 0..MAX_DIM-1
    localparam int ACC_W       = 16;   // signed rounding error term
    localparam int SAMPLE_BITS = 32;

    // Configuration register map
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_DEPTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_DEPTH  = 3'd5;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // Effective extents per axis, both in 1..MAX_DIM with dst <= src
    typedef struct packed {
        logic [AXES-1:0][DIM_W-1:0] src;
        logic [AXES-1:0][DIM_W-1:0] dst;
    } t_extents;

    // Per-axis status seen by the top level
    typedef struct packed {
        logic hit;     // current coordinate is the selected one
        logic at_end;  // destination index is the final one on this axis
        logic wrap;    // current coordinate is the final source coordinate
    } t_axis_stat;

    // One result transaction
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } t_result;

    // Source extent: zero acts as one, anything above MAX_DIM acts as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_src(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    // Destination extent: zero acts as one, clamped to the effective source.
    function automatic logic [DIM_W-1:0] eff_dst(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] s);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end
        if (r > s) begin
            r = s;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vnd_cfg.sv
// Configuration register file and effective extent registers.
// Depends on vnd_pkg.
`default_nettype none

module vnd_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [vnd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [vnd_pkg::DIM_W-1:0]     i_cfg_data,
    output vnd_pkg::t_extents                  o_ext,
    output logic                               o_restart
);
    import vnd_pkg::*;

    logic [NUM_REGS-1:0][DIM_W-1:0] r_cfg;
    logic [NUM_REGS-1:0][DIM_W-1:0] n_cfg;
    t_extents                       r_ext;
    t_extents                       n_ext;
    logic                           w_write;

    assign o_cfg_ready = 1'b1;

    // A write to an index past the register map is dropped without a restart.
    assign w_write   = i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS));
    assign o_restart = w_write;
    assign o_ext     = r_ext;

    // Next register contents and the clamped extents they imply.
    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (i_cfg_index)
                REG_SRC_WIDTH:  n_cfg[0] = i_cfg_data;
                REG_SRC_HEIGHT: n_cfg[1] = i_cfg_data;
                REG_SRC_DEPTH:  n_cfg[2] = i_cfg_data;
                REG_DST_WIDTH:  n_cfg[3] = i_cfg_data;
                REG_DST_HEIGHT: n_cfg[4] = i_cfg_data;
                REG_DST_DEPTH:  n_cfg[5] = i_cfg_data;
                default:        n_cfg    = r_cfg;
            endcase
        end
        for (int a = 0; a < AXES; a++) begin
            n_ext.src[a] = eff_src(n_cfg[a]);
            n_ext.dst[a] = eff_dst(n_cfg[AXES + a], eff_src(n_cfg[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= DIM_W'(1);
            end
            for (int a = 0; a < AXES; a++) begin
                r_ext.src[a] <= DIM_W'(1);
                r_ext.dst[a] <= DIM_W'(1);
            end
        end else begin
            r_cfg <= n_cfg;
            r_ext <= n_ext;
        end
    end

endmodule

`default_nettype wire

>>> rtl/vnd_axis.sv
// Per-axis coordinate tracker: source position, destination index and an
// exact integer rounding error term that marks selected coordinates.
// Depends on vnd_pkg.
`default_nettype none

module vnd_axis (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic                      i_restart,
    input  wire logic [vnd_pkg::DIM_W-1:0] i_src,
    input  wire logic [vnd_pkg::DIM_W-1:0] i_dst,
    output vnd_pkg::t_axis_stat            o_stat
);
    import vnd_pkg::*;

    // r_err = 2*k*src - 2*dst*pos; the position is selected exactly when
    // -dst <= r_err < dst, which is round-half-up of k*src/dst.
    logic        [POS_W-1:0] r_pos;
    logic        [POS_W-1:0] n_pos;
    logic        [POS_W-1:0] r_idx;
    logic        [POS_W-1:0] n_idx;
    logic signed [ACC_W-1:0] r_err;
    logic signed [ACC_W-1:0] n_err;
    logic signed [ACC_W-1:0] w_dst_s;
    logic signed [ACC_W-1:0] w_err_lo;
    logic                    w_adv;

    assign w_dst_s  = $signed(ACC_W'(i_dst));
    assign w_err_lo = r_err + w_dst_s;

    assign o_stat.hit    = !w_err_lo[ACC_W-1] && (r_err < w_dst_s);
    assign o_stat.at_end = ({1'b0, r_idx} + DIM_W'(1)) == i_dst;
    assign o_stat.wrap   = ({1'b0, r_pos} + DIM_W'(1)) >= i_src;
    assign w_adv         = o_stat.hit && !o_stat.at_end;

    // Restart or step the axis; a wrap sends this axis back to coordinate zero.
    always_comb begin
        n_pos = r_pos;
        n_idx = r_idx;
        n_err = r_err;
        if (i_restart) begin
            n_pos = '0;
            n_idx = '0;
            n_err = '0;
        end else if (i_step) begin
            if (o_stat.wrap) begin
                n_pos = '0;
                n_idx = '0;
                n_err = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_idx = r_idx + POS_W'(w_adv);
                n_err = r_err + (w_adv ? $signed(ACC_W'({i_src, 1'b0})) : ACC_W'(0))
                        - $signed(ACC_W'({i_dst, 1'b0}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_idx <= '0;
            r_err <= '0;
        end else begin
            r_pos <= n_pos;
            r_idx <= n_idx;
            r_err <= n_err;
        end
    end

    // The destination index never runs past the clamped destination extent.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_idx} < i_dst))
        else $error("destination index beyond destination extent");

    // The source position never runs past the source extent.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pos} < i_src))
        else $error("source position beyond source extent");

endmodule

`default_nettype wire

>>> rtl/vnd_outbuf.sv
// Two-entry result buffer (main register plus skid register) that decouples
// the input stall from the output stall. Depends on vnd_pkg.
`default_nettype none

module vnd_outbuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire vnd_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output vnd_pkg::t_result      o_data
);
    import vnd_pkg::*;

    logic    r_main_valid;
    logic    n_main_valid;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_main;
    t_result n_main;
    t_result r_skid;
    t_result n_skid;
    logic    w_pop;

    assign w_pop   = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_full  = r_skid_valid;

    // Move the skid entry forward on a pop, then place any new result.
    always_comb begin
        n_main       = r_main;
        n_skid       = r_skid;
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        if (w_pop) begin
            n_main       = r_skid;
            n_main_valid = r_skid_valid;
            n_skid_valid = 1'b0;
        end
        if (i_push) begin
            if (n_main_valid) begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end else begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    // The skid entry is only ever occupied behind an occupied main entry.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry holds a result while main entry is empty");

    // No result arrives while both entries are occupied.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into a full buffer");

    // A stalled skid entry stays put with its contents intact.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost while output stalled");

endmodule

`default_nettype wire

>>> rtl/volume_nearest_downsampler.sv
// Top level of the volume nearest-neighbor downsampler: configuration block,
// three axis trackers and the result buffer. Depends on vnd_pkg, vnd_cfg,
// vnd_axis and vnd_outbuf.
//
//   Channel   Direction  Handshake             Payload
//   input     in         i_valid / o_stall     i_sample
//   result    out        o_valid / i_stall     o_out_sample, o_out_last
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One source sample is taken every cycle that o_stall is low; the pick
// decision is made in the accept cycle; selected samples enter the result buffer.
// o_stall rises only when both entries of the two-deep result buffer are full.
// Synchronous active-low reset sets all extents to one and the traversal
// to the volume origin; a write to a mapped register restarts it as well.
// o_cfg_ready is always high.
`default_nettype none

module volume_nearest_downsampler (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Source samples
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [vnd_pkg::SAMPLE_BITS-1:0] i_sample,
    // Selected samples
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [vnd_pkg::SAMPLE_BITS-1:0]      o_out_sample,
    output logic                                 o_out_last,
    // Register writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [vnd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vnd_pkg::DIM_W-1:0]       i_cfg_data
);
    import vnd_pkg::*;

    t_extents              w_ext;
    logic                  w_restart;
    t_axis_stat            w_stat [AXES];
    logic [AXES-1:0]       w_step;
    logic                  w_accept;
    logic                  w_emit;
    t_result               w_res;
    t_result               w_out;

    assign w_accept = i_valid && !o_stall;

    // Each axis steps when the faster axis below it wraps.
    assign w_step[AXIS_X] = w_accept;
    assign w_step[AXIS_Y] = w_accept && w_stat[AXIS_X].wrap;
    assign w_step[AXIS_Z] = w_step[AXIS_Y] && w_stat[AXIS_Y].wrap;

    vnd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ext       (w_ext),
        .o_restart   (w_restart)
    );

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        vnd_axis u_axis (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (w_step[a]),
            .i_restart (w_restart),
            .i_src     (w_ext.src[a]),
            .i_dst     (w_ext.dst[a]),
            .o_stat    (w_stat[a])
        );
    end

    // A sample passes when all three coordinates are selected.
    assign w_emit = w_accept && w_stat[AXIS_X].hit && w_stat[AXIS_Y].hit
                    && w_stat[AXIS_Z].hit;
    assign w_res.sample = i_sample;
    assign w_res.last   = w_stat[AXIS_X].at_end && w_stat[AXIS_Y].at_end
                          && w_stat[AXIS_Z].at_end;

    vnd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_data  (w_res),
        .o_full  (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_out_sample = w_out.sample;
    assign o_out_last   = w_out.last;

endmodule

`default_nettype wire

>>> bench/vnd_voxel_checker.sv
// Scoreboard for the volume nearest-neighbor downsampler: tracks the source
// traversal, predicts which voxels pass and compares every result transaction.
// Depends on vnd_pkg only.
`default_nettype none

module vnd_voxel_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Source channel, as seen by the block
    input  wire logic                            i_src_valid,
    input  wire logic                            i_src_stall,
    input  wire logic [vnd_pkg::SAMPLE_BITS-1:0] i_src_sample,
    // Result channel, as seen by the block
    input  wire logic                            i_res_valid,
    input  wire logic                            i_res_stall,
    input  wire logic [vnd_pkg::SAMPLE_BITS-1:0] i_res_sample,
    input  wire logic                            i_res_last,
    // Register write channel
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [vnd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vnd_pkg::DIM_W-1:0]       i_cfg_data,
    // Status for the testbench top
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import vnd_pkg::*;

    localparam int REPORT_LIMIT = 40;

    // Shadow registers and traversal state
    logic [DIM_W-1:0] regs      [NUM_REGS];
    logic [POS_W-1:0] coord     [AXES];
    logic [POS_W-1:0] pick      [AXES];
    logic [POS_W-1:0] dst_index [AXES];
    logic [13:0]      remainder [AXES];

    // Voxels that should come out, oldest first
    t_result selected_voxels [$];
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    // Source extent in effect on one axis.
    function automatic int src_span(input int a);
        int v;
        v = int'(regs[a]);
        if (v < 1) v = 1;
        if (v > MAX_DIM) v = MAX_DIM;
        return v;
    endfunction

    // Destination extent in effect on one axis, never above the source.
    function automatic int dst_span(input int a);
        int v;
        v = int'(regs[AXES + a]);
        if (v < 1) v = 1;
        if (v > src_span(a)) v = src_span(a);
        return v;
    endfunction

    // Source coordinate chosen by the current destination index, half up.
    task automatic aim_axis(input int a);
        longint n;
        longint q;
        longint r;
        n = longint'(dst_index[a]) * longint'(src_span(a));
        q = n / dst_span(a);
        r = n % dst_span(a);
        remainder[a] = 14'(r);
        pick[a] = POS_W'(q + ((2 * r >= dst_span(a)) ? 1 : 0));
    endtask

    // Back to the volume origin.
    task automatic restart_volume();
        for (int a = 0; a < AXES; a++) begin
            coord[a] = '0;
            dst_index[a] = '0;
            aim_axis(a);
        end
    endtask

    // A hit moves the destination index on, unless it already sits at its end.
    task automatic step_index(input int a, input bit hit);
        if (hit && int'(dst_index[a]) + 1 < dst_span(a)) begin
            dst_index[a] = dst_index[a] + 1'b1;
            aim_axis(a);
        end
    endtask

    // Decide on one source voxel and move the traversal one step on.
    task automatic predict_voxel(input logic [SAMPLE_BITS-1:0] value);
        bit      hit [AXES];
        bit      emit;
        bit      last;
        t_result item;
        emit = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            hit[a] = (coord[a] == pick[a]);
            emit &= hit[a];
        end
        last = emit;
        for (int a = 0; a < AXES; a++) begin
            if (int'(dst_index[a]) + 1 != dst_span(a)) last = 1'b0;
        end
        // An axis only moves when every faster axis has wrapped.
        for (int a = 0; a < AXES; a++) begin
            step_index(a, hit[a]);
            if (int'(coord[a]) + 1 >= src_span(a)) begin
                coord[a] = '0;
                dst_index[a] = '0;
                aim_axis(a);
            end else begin
                coord[a] = coord[a] + 1'b1;
                break;
            end
        end
        if (emit) begin
            item.sample = value;
            item.last = last;
            selected_voxels.push_back(item);
        end
    endtask

    // Results are compared before this edge's source transaction is predicted,
    // since a voxel can leave the block in the cycle after it entered at the earliest.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) regs[i] = DIM_W'(1);
            restart_volume();
            selected_voxels.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (selected_voxels.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, actual %h last %b",
                                 $time, i_res_sample, i_res_last);
                    fail_count++;
                end else begin
                    want = selected_voxels.pop_front();
                    if (i_res_sample !== want.sample) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: out_sample mismatch, expected %h, actual %h",
                                     $time, want.sample, i_res_sample);
                        fail_count++;
                    end
                    if (i_res_last !== want.last) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: out_last mismatch, expected %b, actual %b",
                                     $time, want.last, i_res_last);
                        fail_count++;
                    end
                end
            end
            // Writes to a register outside the map change nothing.
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_REGS) begin
                regs[i_cfg_index] = i_cfg_data;
                restart_volume();
            end
            if (i_src_valid && !i_src_stall) predict_voxel(i_src_sample);
        end
        o_pending <= selected_voxels.size();
    end

endmodule

`default_nettype wire

>>> bench/volume_nearest_downsampler_tb.sv
// Testbench top for the volume nearest-neighbor downsampler: clock, reset,
// register writes, source and sink traffic and the verdict.
// Depends on vnd_pkg, volume_nearest_downsampler and vnd_voxel_checker.
`default_nettype none

module volume_nearest_downsampler_tb;
    import vnd_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int QUIET_AFTER  = 580;
    localparam int HOLD_CYCLES  = 48;
    localparam int SETTLE       = 4;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   o_valid;
    logic                   i_stall;
    logic [SAMPLE_BITS-1:0] o_out_sample;
    logic                   o_out_last;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [DIM_W-1:0]       i_cfg_data;

    int fail_count;
    int pending;
    int random_sent = 0;
    int hold_asked  = 0;
    int hold_given  = 0;
    bit quiet_tail  = 1'b0;
    bit leftover    = 1'b0;

    volume_nearest_downsampler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_sample (o_out_sample),
        .o_out_last   (o_out_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    vnd_voxel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_src_valid  (i_valid),
        .i_src_stall  (o_stall),
        .i_src_sample (i_sample),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res_sample (o_out_sample),
        .i_res_last   (o_out_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Sink: random stall bursts, one long hold on request, none in the tail.
    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_asked != hold_given) begin
                hold_given = hold_asked;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Extent that the block will use for a source register value.
    function automatic int src_extent(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
        return int'(v);
    endfunction

    // One source transaction, with an occasional gap in front of it.
    task automatic send_voxel(input logic [SAMPLE_BITS-1:0] value);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_voxel($urandom);
        i_valid <= 1'b0;
    endtask

    // Register write; valid stays up for back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Wait until every predicted voxel has arrived, then let the block settle,
    // since the last source voxels may have been dropped.
    task automatic drain_results();
        int guard;
        repeat (2) @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending != 0) begin
            $display("%0t: %0d selected voxels never arrived, expected 0, actual %0d",
                     $time, pending, pending);
            leftover = 1'b1;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic [DIM_W-1:0] ext [NUM_REGS];
        int               vol;
        int               n;
        int               start;
        int               r;
        bit               first_phase;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset extents are all one: every voxel passes and closes a volume.
        send_voxel(32'h0000_0000);
        send_voxel(32'hFFFF_FFFF);
        i_valid <= 1'b0;
        drain_results();

        // 3x2x2 source onto 2x2x1, with writes outside the map mid-volume.
        write_reg(REG_SRC_WIDTH, DIM_W'(3));
        write_reg(REG_SRC_HEIGHT, DIM_W'(2));
        write_reg(REG_SRC_DEPTH, DIM_W'(2));
        write_reg(REG_DST_WIDTH, DIM_W'(2));
        write_reg(REG_DST_HEIGHT, DIM_W'(2));
        write_reg(REG_DST_DEPTH, DIM_W'(1));
        i_cfg_valid <= 1'b0;
        send_voxel(32'hAAAA_AAAA);
        send_voxel(32'h5555_5555);
        send_random(4);
        drain_results();
        // These must not restart the traversal.
        write_reg(CFG_IDX_W'(NUM_REGS), {DIM_W{1'b1}});
        write_reg(CFG_IDX_W'(NUM_REGS + 1), '0);
        i_cfg_valid <= 1'b0;
        send_random(6);
        drain_results();

        // Zero extents, an oversized source and a destination above its source.
        write_reg(REG_SRC_WIDTH, '0);
        write_reg(REG_SRC_HEIGHT, {DIM_W{1'b1}});
        write_reg(REG_SRC_DEPTH, DIM_W'(MAX_DIM));
        write_reg(REG_DST_WIDTH, '0);
        write_reg(REG_DST_HEIGHT, DIM_W'(5));
        write_reg(REG_DST_DEPTH, {DIM_W{1'b1}});
        i_cfg_valid <= 1'b0;
        send_random(6);
        drain_results();

        // Random phases; the first one fills the block behind a long sink hold.
        first_phase = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= QUIET_AFTER) quiet_tail = 1'b1;
            if (first_phase) begin
                for (int a = 0; a < AXES; a++) begin
                    ext[a] = (a == AXIS_Z) ? DIM_W'(1) : DIM_W'(8);
                    ext[AXES + a] = ext[a];
                end
                n = 64;
            end else if ($urandom_range(0, 7) == 0) begin
                // Large extents: only the first rows of the volume are reached.
                for (int a = 0; a < AXES; a++) begin
                    case ($urandom_range(0, 3))
                        0:       ext[a] = DIM_W'(MAX_DIM);
                        1:       ext[a] = {DIM_W{1'b1}};
                        2:       ext[a] = DIM_W'($urandom_range(1, 8191));
                        default: ext[a] = DIM_W'($urandom_range(1, 5));
                    endcase
                    case ($urandom_range(0, 3))
                        0:       ext[AXES + a] = ext[a];
                        1:       ext[AXES + a] = DIM_W'(MAX_DIM - 1);
                        2:       ext[AXES + a] = DIM_W'($urandom_range(0, 1));
                        default: ext[AXES + a] = DIM_W'($urandom_range(0, 8191));
                    endcase
                end
                n = $urandom_range(30, 90);
            end else begin
                // Small volumes streamed whole, so that every volume end is seen.
                for (int a = 0; a < AXES; a++) ext[a] = DIM_W'($urandom_range(1, 5));
                if ($urandom_range(0, 3) == 0) ext[AXIS_Z] = DIM_W'(1);
                for (int a = 0; a < AXES; a++)
                    ext[AXES + a] = DIM_W'($urandom_range(0, int'(ext[a]) + 2));
                vol = src_extent(ext[AXIS_X]) * src_extent(ext[AXIS_Y])
                      * src_extent(ext[AXIS_Z]);
                n = vol * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, vol);
            end

            start = $urandom_range(0, NUM_REGS - 1);
            for (int i = 0; i < NUM_REGS; i++) begin
                r = (start + i) % NUM_REGS;
                write_reg(CFG_IDX_W'(r), ext[r]);
            end
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 1)),
                          DIM_W'($urandom_range(0, 8191)));
            i_cfg_valid <= 1'b0;

            if (first_phase) hold_asked <= hold_asked + 1;
            first_phase = 1'b0;
            send_random(n);
            random_sent += n;
            drain_results();
        end

        if (fail_count == 0 && !leftover) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
